// ===== hw/rtl/vcsd_pkg.sv =====
// shared types and constants of the voxel column span decoder
package vcsd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned COL_W = 16;
	localparam int unsigned LEN_W = 12;
	localparam int unsigned POS_W = 11;
	localparam int unsigned ZCUR_W = 9;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned MAX_COLUMN_BYTES = 2048;
	localparam int unsigned DIV_STEPS = COL_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] CFG_X_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Z_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STRICT = 2'd2;

	localparam logic KIND_VOXEL = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] x_size;
		logic [BYTE_W-1:0] z_size;
		logic              strict_mode;
	} cfg_t;

	typedef struct packed {
		logic              kind;
		logic [COL_W-1:0]  col;
		logic [BYTE_W-1:0] z;
		logic [BYTE_W-1:0] colour;
		logic [BYTE_W-1:0] normal;
		logic              ok;
	} entry_t;

endpackage

// ===== hw/rtl/vcsd_front.sv =====
// front end: takes column bytes, runs the span parser, queues voxel and status records
module vcsd_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [vcsd_pkg::BYTE_W-1:0]    data_byte,
	input  logic [vcsd_pkg::COL_W-1:0]     col_index,
	input  logic [vcsd_pkg::LEN_W-1:0]     column_length,
	input  vcsd_pkg::cfg_t                 cfg,
	input  logic                           fifo_full,
	output logic                           push,
	output vcsd_pkg::entry_t               entry
);

	typedef enum logic [5:0] {
		PH_SKIP   = 6'b000001,
		PH_COUNT  = 6'b000010,
		PH_TRAIL  = 6'b000100,
		PH_COLOUR = 6'b001000,
		PH_NORMAL = 6'b010000,
		PH_REPEAT = 6'b100000
	} phase_t;

	phase_t                            phase_q, phase_d;
	logic [vcsd_pkg::POS_W-1:0]        pos_q;
	logic [vcsd_pkg::ZCUR_W-1:0]       z_q, z_d;
	logic [vcsd_pkg::BYTE_W-1:0]       cnt_q, cnt_d;
	logic [vcsd_pkg::BYTE_W-1:0]       rem_q, rem_d;
	logic [vcsd_pkg::BYTE_W-1:0]       colour_q, colour_d;
	logic                              verdict_q, verdict_d;
	logic                              stopped_q, stopped_d;

	logic [vcsd_pkg::LEN_W-1:0]        len_c;
	logic [vcsd_pkg::LEN_W-1:0]        pos_inc;
	logic [vcsd_pkg::LEN_W-1:0]        span_end;
	logic [vcsd_pkg::ZCUR_W:0]         depth_sum;
	logic                              last;
	logic                              trunc;
	logic                              too_deep;
	logic                              voxel;
	logic [vcsd_pkg::BYTE_W-1:0]       vz;
	logic                              accept;

	assign in_stall = fifo_full;
	assign accept = in_valid && !fifo_full;

	always_comb begin
		if (column_length == '0) begin
			len_c = vcsd_pkg::LEN_W'(1);
		end else if (column_length > vcsd_pkg::LEN_W'(vcsd_pkg::MAX_COLUMN_BYTES)) begin
			len_c = vcsd_pkg::LEN_W'(vcsd_pkg::MAX_COLUMN_BYTES);
		end else begin
			len_c = column_length;
		end
	end

	assign pos_inc = {1'b0, pos_q} + vcsd_pkg::LEN_W'(1);
	assign last = pos_inc >= len_c;
	assign span_end = {1'b0, pos_q} + {3'b000, data_byte, 1'b0} + vcsd_pkg::LEN_W'(2);
	assign trunc = span_end > len_c;
	assign depth_sum = {1'b0, z_q} + {2'b00, data_byte};
	assign too_deep = depth_sum > {2'b00, cfg.z_size};

	always_comb begin
		phase_d = phase_q;
		z_d = z_q;
		cnt_d = cnt_q;
		rem_d = rem_q;
		colour_d = colour_q;
		verdict_d = verdict_q;
		stopped_d = stopped_q;
		voxel = 1'b0;
		vz = '0;
		if (!stopped_q) begin
			if (cfg.x_size == '0) begin
				verdict_d = 1'b0;
				stopped_d = 1'b1;
			end else begin
				case (phase_q)
					PH_SKIP: begin
						z_d = z_q + {1'b0, data_byte};
						if (last) begin
							verdict_d = !cfg.strict_mode;
							stopped_d = 1'b1;
						end else begin
							phase_d = PH_COUNT;
						end
					end
					PH_COUNT: begin
						if (data_byte == '0) begin
							if (last) begin
								verdict_d = !cfg.strict_mode;
								stopped_d = 1'b1;
							end else begin
								phase_d = PH_TRAIL;
							end
						end else if (too_deep || trunc) begin
							verdict_d = !cfg.strict_mode;
							stopped_d = 1'b1;
						end else begin
							cnt_d = data_byte;
							rem_d = data_byte;
							phase_d = PH_COLOUR;
						end
					end
					PH_TRAIL: begin
						verdict_d = !(cfg.strict_mode && (data_byte != '0 ||
							z_q != {1'b0, cfg.z_size} || !last));
						stopped_d = 1'b1;
					end
					PH_COLOUR: begin
						colour_d = data_byte;
						phase_d = PH_NORMAL;
						if (last) begin
							verdict_d = !cfg.strict_mode;
							stopped_d = 1'b1;
						end
					end
					PH_NORMAL: begin
						vz = z_q[vcsd_pkg::BYTE_W-1:0];
						voxel = 1'b1;
						z_d = z_q + vcsd_pkg::ZCUR_W'(1);
						rem_d = rem_q - vcsd_pkg::BYTE_W'(1);
						phase_d = (rem_d != '0) ? PH_COLOUR : PH_REPEAT;
						if (last) begin
							verdict_d = !cfg.strict_mode;
							stopped_d = 1'b1;
						end
					end
					PH_REPEAT: begin
						if (cfg.strict_mode && data_byte != cnt_q) begin
							verdict_d = 1'b0;
							stopped_d = 1'b1;
						end else begin
							phase_d = PH_SKIP;
						end
					end
					default: begin
						verdict_d = !cfg.strict_mode;
						stopped_d = 1'b1;
					end
				endcase
			end
		end
	end

	assign push = accept && (last || voxel);

	always_comb begin
		entry.kind = last ? vcsd_pkg::KIND_STATUS : vcsd_pkg::KIND_VOXEL;
		entry.col = col_index;
		entry.z = last ? '0 : vz;
		entry.colour = last ? '0 : colour_d;
		entry.normal = last ? '0 : data_byte;
		entry.ok = last ? verdict_d : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			pos_q <= '0;
			z_q <= '0;
			cnt_q <= '0;
			rem_q <= '0;
			colour_q <= '0;
			verdict_q <= 1'b1;
			stopped_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				phase_q <= PH_SKIP;
				pos_q <= '0;
				z_q <= '0;
				cnt_q <= '0;
				rem_q <= '0;
				colour_q <= '0;
				verdict_q <= 1'b1;
				stopped_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				pos_q <= pos_inc[vcsd_pkg::POS_W-1:0];
				z_q <= z_d;
				cnt_q <= cnt_d;
				rem_q <= rem_d;
				colour_q <= colour_d;
				verdict_q <= verdict_d;
				stopped_q <= stopped_d;
			end
		end
	end

endmodule

// ===== hw/rtl/vcsd_fifo.sv =====
// two-entry record queue between the parser and the output side
module vcsd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vcsd_pkg::entry_t push_entry,
	input  logic             pop,
	output vcsd_pkg::entry_t head,
	output logic             full,
	output logic             empty
);

	vcsd_pkg::entry_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/vcsd_back.sv =====
// back end: serial divide for x and y, output register for records
module vcsd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vcsd_pkg::entry_t            head,
	input  logic                        empty,
	input  logic [vcsd_pkg::BYTE_W-1:0] x_size,
	output logic                        pop,
	output logic                        div_busy,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        result_kind,
	output logic [vcsd_pkg::BYTE_W-1:0] voxel_x,
	output logic [vcsd_pkg::BYTE_W-1:0] voxel_y,
	output logic [vcsd_pkg::BYTE_W-1:0] voxel_z,
	output logic [vcsd_pkg::BYTE_W-1:0] voxel_colour,
	output logic [vcsd_pkg::BYTE_W-1:0] voxel_normal,
	output logic                        column_ok
);

	typedef enum logic [1:0] {
		BK_RUN = 2'b01,
		BK_DIV = 2'b10
	} bk_state_t;

	bk_state_t                        state_q;
	logic                             cache_valid_q;
	logic [vcsd_pkg::COL_W-1:0]       cache_col_q;
	logic [vcsd_pkg::BYTE_W-1:0]      cache_div_q;
	logic [vcsd_pkg::BYTE_W-1:0]      x_q;
	logic [vcsd_pkg::BYTE_W-1:0]      y_q;
	logic [vcsd_pkg::COL_W-1:0]       dq_q;
	logic [vcsd_pkg::BYTE_W-1:0]      prem_q;
	logic [vcsd_pkg::DIV_CNT_W-1:0]   cnt_q;

	logic                             out_valid_q;
	logic                             result_kind_q;
	logic [vcsd_pkg::BYTE_W-1:0]      voxel_x_q;
	logic [vcsd_pkg::BYTE_W-1:0]      voxel_y_q;
	logic [vcsd_pkg::BYTE_W-1:0]      voxel_z_q;
	logic [vcsd_pkg::BYTE_W-1:0]      voxel_colour_q;
	logic [vcsd_pkg::BYTE_W-1:0]      voxel_normal_q;
	logic                             column_ok_q;

	logic                             out_free;
	logic                             hit;
	logic                             is_status;
	logic                             start_div;
	logic [vcsd_pkg::BYTE_W:0]        trial;
	logic                             ge;
	logic [vcsd_pkg::BYTE_W:0]        diff;
	logic [vcsd_pkg::BYTE_W-1:0]      prem_n;
	logic [vcsd_pkg::COL_W-1:0]       dq_n;

	assign out_free = !out_valid_q || !out_stall;
	assign is_status = head.kind == vcsd_pkg::KIND_STATUS;
	assign hit = cache_valid_q && cache_col_q == head.col && cache_div_q == x_size;
	assign pop = state_q == BK_RUN && !empty && (is_status || hit) && out_free;
	assign start_div = state_q == BK_RUN && !empty && !is_status && !hit;
	assign div_busy = state_q == BK_DIV;

	// one quotient bit per cycle, restoring
	assign trial = {prem_q, dq_q[vcsd_pkg::COL_W-1]};
	assign ge = trial >= {1'b0, cache_div_q};
	assign diff = trial - {1'b0, cache_div_q};
	assign prem_n = ge ? diff[vcsd_pkg::BYTE_W-1:0] : trial[vcsd_pkg::BYTE_W-1:0];
	assign dq_n = {dq_q[vcsd_pkg::COL_W-2:0], ge};

	always_ff @(posedge clk) begin
		if (start_div) begin
			dq_q <= head.col;
			prem_q <= '0;
			cache_col_q <= head.col;
			cache_div_q <= x_size;
		end else if (state_q == BK_DIV) begin
			dq_q <= dq_n;
			prem_q <= prem_n;
			if (cnt_q == vcsd_pkg::DIV_CNT_W'(vcsd_pkg::DIV_STEPS - 1)) begin
				x_q <= prem_n;
				y_q <= dq_n[vcsd_pkg::BYTE_W-1:0];
			end
		end
		if (pop) begin
			result_kind_q <= head.kind;
			voxel_x_q <= is_status ? '0 : x_q;
			voxel_y_q <= is_status ? '0 : y_q;
			voxel_z_q <= head.z;
			voxel_colour_q <= head.colour;
			voxel_normal_q <= head.normal;
			column_ok_q <= head.ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_RUN;
			cache_valid_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				BK_RUN: begin
					if (start_div) begin
						state_q <= BK_DIV;
						cache_valid_q <= 1'b0;
						cnt_q <= '0;
					end
				end
				BK_DIV: begin
					cnt_q <= cnt_q + vcsd_pkg::DIV_CNT_W'(1);
					if (cnt_q == vcsd_pkg::DIV_CNT_W'(vcsd_pkg::DIV_STEPS - 1)) begin
						state_q <= BK_RUN;
						cache_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= BK_RUN;
					cache_valid_q <= 1'b0;
				end
			endcase
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = result_kind_q;
	assign voxel_x = voxel_x_q;
	assign voxel_y = voxel_y_q;
	assign voxel_z = voxel_z_q;
	assign voxel_colour = voxel_colour_q;
	assign voxel_normal = voxel_normal_q;
	assign column_ok = column_ok_q;

endmodule

// ===== hw/rtl/voxel_column_span_decoder.sv =====
// top level of the voxel column span decoder
// The decoder takes one column byte per cycle as long as its two-entry record queue has
// room; bytes that yield no record do not enter the queue. Each voxel needs x and y, the column
// index split by x_size, which the back end forms with a bit-serial divider of 16 steps;
// the result is kept and reused while the column index and x_size stay the same, so the
// first voxel of a new column waits while the divider is loaded and runs its 16 steps, and
// later voxels of the column pass with no extra wait. While the divider runs the queue
// fills after two records and the input stalls. A status record leaves on the column's last
// byte. There is no memory and no clearing pass after reset. Write x_size, z_size and
// strict_mode only while idle.
module voxel_column_span_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [vcsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vcsd_pkg::BYTE_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [vcsd_pkg::BYTE_W-1:0]    data_byte,
	input  logic [vcsd_pkg::COL_W-1:0]     col_index,
	input  logic [vcsd_pkg::LEN_W-1:0]     column_length,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           result_kind,
	output logic [vcsd_pkg::BYTE_W-1:0]    voxel_x,
	output logic [vcsd_pkg::BYTE_W-1:0]    voxel_y,
	output logic [vcsd_pkg::BYTE_W-1:0]    voxel_z,
	output logic [vcsd_pkg::BYTE_W-1:0]    voxel_colour,
	output logic [vcsd_pkg::BYTE_W-1:0]    voxel_normal,
	output logic                           column_ok
);

	vcsd_pkg::cfg_t   cfg_q;
	vcsd_pkg::entry_t push_entry;
	vcsd_pkg::entry_t head;
	logic             push;
	logic             pop;
	logic             fifo_full;
	logic             fifo_empty;
	logic             div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				vcsd_pkg::CFG_X_SIZE: cfg_q.x_size <= cfg_data;
				vcsd_pkg::CFG_Z_SIZE: cfg_q.z_size <= cfg_data;
				vcsd_pkg::CFG_STRICT: cfg_q.strict_mode <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	vcsd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.col_index     (col_index),
		.column_length (column_length),
		.cfg           (cfg_q),
		.fifo_full     (fifo_full),
		.push          (push),
		.entry         (push_entry)
	);

	vcsd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (fifo_full),
		.empty      (fifo_empty)
	);

	vcsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (fifo_empty),
		.x_size       (cfg_q.x_size),
		.pop          (pop),
		.div_busy     (div_busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.voxel_x      (voxel_x),
		.voxel_y      (voxel_y),
		.voxel_z      (voxel_z),
		.voxel_colour (voxel_colour),
		.voxel_normal (voxel_normal),
		.column_ok    (column_ok)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_full)
		else $error("record queue written while full");

	a_no_pop_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !pop)
		else $error("record released while divider busy");

	a_voxel_no_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == vcsd_pkg::KIND_VOXEL |-> !column_ok)
		else $error("voxel record carries a column verdict");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == vcsd_pkg::KIND_STATUS |->
			voxel_x == '0 && voxel_y == '0 && voxel_z == '0 &&
			voxel_colour == '0 && voxel_normal == '0)
		else $error("status record carries voxel fields");

endmodule
